/* src/lph_pkg.sv */
// Package for the linear-probe hash table: field widths, operation,
// status and slot-tag codes, and the controller/datapath structs.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package lph_pkg;

    // Default number of slots.
    localparam int DEF_TABLE_SIZE = 16;

    // Widths of the word fields.
    localparam int KIND_W    = 2;
    localparam int KEY_W     = 64;
    localparam int HASH_W    = 31;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 4;
    localparam int ENTRIES_W = 5;

    // Operation codes carried in the kind field.
    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_SEARCH = 2'd2
    } t_kind;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // Per-slot tag.
    typedef enum logic [1:0] {
        TAG_EMPTY   = 2'd0,
        TAG_LIVE    = 2'd1,
        TAG_DELETED = 2'd2
    } t_tag;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ready;
        logic clear;
        logic home_step;
        logic read_first;
        logic probe;
        logic finish;
    } t_lph_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic req_valid;
        logic req_kind_ok;
        logic mod_needed;
        logic home_done;
        logic probe_hit;
        logic probe_miss;
        logic out_free;
    } t_lph_stat;

endpackage

/* src/lph_if.sv */
// Handshake interfaces for the request and response channels.
// Depends on lph_pkg for the field widths.
`timescale 1ns / 1ps

interface lph_req_if import lph_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic [HASH_W-1:0] hash_value;

    modport source (output valid, kind, key, hash_value, input ready);
    modport sink   (input valid, kind, key, hash_value, output ready);
endinterface

interface lph_rsp_if import lph_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [SLOT_W-1:0]    slot_index;
    logic [ENTRIES_W-1:0] entries;

    modport source (output valid, status, slot_index, entries, input ready);
    modport sink   (input valid, status, slot_index, entries, output ready);
endinterface

/* src/linear_probe_hash_table_core.sv */
// Channel  Dir  Word fields                      Handshake
// i_req    in   kind[1:0] key[63:0] hash[30:0]   i_req.valid / i_req.ready
// o_rsp    out  status[1:0] slot[3:0] ent[4:0]   o_rsp.valid / o_rsp.ready
//
// One word is processed at a time. An operation probes 1 to TABLE_SIZE
// slots; with a table size that is not a power of two, the home-slot
// remainder is computed before probing begins. Probing reads
// one slot per cycle from the tag and key memories.
// After reset a clearing pass empties the tag memory; no word is accepted
// until it ends. A stalled response holds the block in its write-back step;
// the next request is taken once the response is free.
// Top level of the linear-probe hash table: controller plus datapath.
// Depends on lph_pkg, lph_if, lph_ctrl and lph_dp.
`timescale 1ns / 1ps

module linear_probe_hash_table_core import lph_pkg::*; #(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lph_req_if.sink   i_req,
    lph_rsp_if.source o_rsp
);

    t_lph_cmd  cmd;
    t_lph_stat stat;

    // Sequencer.
    lph_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Memories and arithmetic.
    lph_dp #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );

`ifndef SYNTHESIS
    // An accepted request keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted on two consecutive cycles");

    // Write-back with a free response slot always presents a response word.
    a_finish_loads_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.finish && stat.out_free) |=> o_rsp.valid)
        else $error("write-back did not present a response word");

    // A failed operation reports slot zero.
    a_fail_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != ST_OK)) |-> (o_rsp.slot_index == '0))
        else $error("failed operation reported a nonzero slot");
`endif

endmodule

/* src/lph_ctrl.sv */
// Controller of the hash table: one-hot state machine that sequences the
// clearing pass, home-slot reduction, probing and result write-back.
// Depends on lph_pkg for the command and status structs.
`timescale 1ns / 1ps

module lph_ctrl import lph_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_lph_stat i_stat,
    output t_lph_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_HOME   = 6'b000100,
        S_READ   = 6'b001000,
        S_PROBE  = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_stat.req_valid) begin
                    if (!i_stat.req_kind_ok) begin
                        n_state = S_FINISH;
                    end else if (i_stat.mod_needed) begin
                        n_state = S_HOME;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_HOME: begin
                if (i_stat.home_done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_PROBE;
            end
            S_PROBE: begin
                if (i_stat.probe_hit || i_stat.probe_miss) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // State register; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Commands follow the state directly.
    always_comb begin
        o_cmd.ready      = (r_state == S_IDLE);
        o_cmd.clear      = (r_state == S_CLEAR);
        o_cmd.home_step  = (r_state == S_HOME);
        o_cmd.read_first = (r_state == S_READ);
        o_cmd.probe      = (r_state == S_PROBE);
        o_cmd.finish     = (r_state == S_FINISH);
    end

endmodule

/* src/lph_dp.sv */
// Datapath of the hash table: slot tag and key memories, reciprocal home-slot
// remainder unit, probe pointer, entry counter and response register.
// Depends on lph_pkg and the lph_req_if / lph_rsp_if interfaces.
`timescale 1ns / 1ps

module lph_dp import lph_pkg::*; #(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lph_req_if.sink      i_req,
    lph_rsp_if.source    o_rsp,
    input  t_lph_cmd     i_cmd,
    output t_lph_stat    o_stat
);

    localparam int IDX_W    = $clog2(TABLE_SIZE);
    localparam int CNT_W    = $clog2(TABLE_SIZE + 1);
    localparam int MODCNT_W = 2;
    localparam int QM_W     = HASH_W + IDX_W + 1;
    localparam bit POW2     = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
    localparam logic [IDX_W-1:0]    LAST_IDX    = IDX_W'(TABLE_SIZE - 1);
    localparam logic [MODCNT_W-1:0] LAST_MODCNT = MODCNT_W'(2);
    localparam logic [HASH_W-1:0]   RECIP       = HASH_W'((64'd1 << HASH_W) / TABLE_SIZE);
    localparam logic [HASH_W-1:0]   SIZE_HASH   = HASH_W'(TABLE_SIZE);

    // Slot memories with registered read data.
    t_tag              r_tag_mem [TABLE_SIZE];
    logic [KEY_W-1:0]  r_key_mem [TABLE_SIZE];
    t_tag              r_tag_q;
    logic [KEY_W-1:0]  r_key_q;

    // Per-operation registers.
    logic [KIND_W-1:0]   r_kind;
    logic [KEY_W-1:0]    r_key;
    logic [IDX_W-1:0]    r_probe;
    logic [IDX_W-1:0]    r_cur;
    logic [IDX_W-1:0]    r_count;
    logic [HASH_W-1:0]   r_mod_hash;
    logic [HASH_W-1:0]   r_mod_q;
    logic [MODCNT_W-1:0] r_mod_cnt;
    t_status             r_res_status;
    logic [IDX_W-1:0]    r_res_slot;

    // Table-wide and response registers.
    logic [IDX_W-1:0]     r_clr_addr;
    logic [CNT_W-1:0]     r_entries;
    logic [CNT_W-1:0]     n_entries;
    logic                 r_out_valid;
    logic [STATUS_W-1:0]  r_out_status;
    logic [SLOT_W-1:0]    r_out_slot;
    logic [ENTRIES_W-1:0] r_out_entries;

    logic                  accept;
    logic                  is_ins;
    logic                  is_del;
    logic [2*HASH_W-1:0]   mod_prod;
    logic [QM_W-1:0]       mod_qm;
    logic [HASH_W-1:0]     mod_diff;
    logic [HASH_W-1:0]     mod_rem;
    logic [IDX_W-1:0]      probe_next;
    logic                  key_eq;
    logic                  stop_ok;
    logic                  stop_empty;
    logic                  out_free;
    logic                  do_write;
    logic                  tag_we;
    logic [IDX_W-1:0]      wr_addr;
    t_tag                  wr_tag;
    logic [31:0]           slot_ext;
    logic [31:0]           entries_ext;

    assign accept = i_req.valid && i_cmd.ready;
    assign is_ins = (r_kind == KIND_INSERT);
    assign is_del = (r_kind == KIND_DELETE);

    // Home-slot remainder in three steps: the quotient estimate from the
    // reciprocal is low by at most one, so the remainder needs one
    // compare and subtract at the end.
    assign mod_prod = (2*HASH_W)'(r_mod_hash) * (2*HASH_W)'(RECIP);
    assign mod_qm   = QM_W'(r_mod_q) * QM_W'(TABLE_SIZE);
    assign mod_diff = r_mod_hash - r_mod_q;
    assign mod_rem  = (mod_diff >= SIZE_HASH) ? (mod_diff - SIZE_HASH) : mod_diff;

    // Probe pointer advances one slot and wraps at the table end.
    assign probe_next = (r_probe == LAST_IDX) ? '0 : (r_probe + 1'b1);

    // Decide on the slot whose tag and key were just read.
    assign key_eq     = (r_key_q == r_key);
    assign stop_ok    = is_ins ? (r_tag_q != TAG_LIVE) : ((r_tag_q == TAG_LIVE) && key_eq);
    assign stop_empty = !is_ins && (r_tag_q == TAG_EMPTY);

    assign out_free = !r_out_valid || o_rsp.ready;
    assign do_write = i_cmd.finish && out_free && (r_res_status == ST_OK)
                      && (is_ins || is_del);

    // Memory write port: clearing pass or result write-back.
    assign tag_we  = i_cmd.clear || do_write;
    assign wr_addr = i_cmd.clear ? r_clr_addr : r_res_slot;
    assign wr_tag  = i_cmd.clear ? TAG_EMPTY : (is_ins ? TAG_LIVE : TAG_DELETED);

    // Entry count after this operation.
    always_comb begin
        n_entries = r_entries;
        if (do_write && is_ins) begin
            n_entries = r_entries + 1'b1;
        end else if (do_write && is_del && (r_entries != '0)) begin
            n_entries = r_entries - 1'b1;
        end
    end

    assign slot_ext    = 32'(r_res_slot);
    assign entries_ext = 32'(n_entries);

    // Tag memory.
    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            r_tag_mem[wr_addr] <= wr_tag;
        end
        r_tag_q <= r_tag_mem[r_probe];
    end

    // Key memory.
    always_ff @(posedge i_clk) begin
        if (do_write && is_ins) begin
            r_key_mem[r_res_slot] <= r_key;
        end
        r_key_q <= r_key_mem[r_probe];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_entries   <= '0;
            r_clr_addr  <= '0;
            r_count     <= '0;
            r_mod_cnt   <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (accept) begin
                r_count   <= '0;
                r_mod_cnt <= '0;
            end
            if (i_cmd.home_step) begin
                r_mod_cnt <= r_mod_cnt + 1'b1;
            end
            if (i_cmd.probe && !o_stat.probe_hit && !o_stat.probe_miss) begin
                r_count <= r_count + 1'b1;
            end
            r_entries <= n_entries;
            if (i_cmd.finish && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Operation payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind       <= i_req.kind;
            r_key        <= i_req.key;
            r_probe      <= i_req.hash_value[IDX_W-1:0];
            r_mod_hash   <= i_req.hash_value;
            r_res_status <= ST_NOT_FOUND;
            r_res_slot   <= '0;
        end
        if (i_cmd.home_step) begin
            if (r_mod_cnt == '0) begin
                r_mod_q <= mod_prod[2*HASH_W-1:HASH_W];
            end else if (o_stat.home_done) begin
                r_probe <= mod_rem[IDX_W-1:0];
            end else begin
                r_mod_q <= mod_qm[HASH_W-1:0];
            end
        end
        if (i_cmd.read_first) begin
            r_cur   <= r_probe;
            r_probe <= probe_next;
        end
        if (i_cmd.probe) begin
            if (o_stat.probe_hit) begin
                r_res_status <= ST_OK;
                r_res_slot   <= r_cur;
            end else if (o_stat.probe_miss) begin
                r_res_status <= is_ins ? ST_FULL : ST_NOT_FOUND;
            end else begin
                r_cur   <= r_probe;
                r_probe <= probe_next;
            end
        end
        if (i_cmd.finish && out_free) begin
            r_out_status  <= r_res_status;
            r_out_slot    <= slot_ext[SLOT_W-1:0];
            r_out_entries <= entries_ext[ENTRIES_W-1:0];
        end
    end

    // Status toward the controller.
    always_comb begin
        o_stat.clr_done    = (r_clr_addr == LAST_IDX);
        o_stat.req_valid   = i_req.valid;
        o_stat.req_kind_ok = (i_req.kind == KIND_INSERT) || (i_req.kind == KIND_DELETE)
                             || (i_req.kind == KIND_SEARCH);
        o_stat.mod_needed  = !POW2;
        o_stat.home_done   = (r_mod_cnt == LAST_MODCNT);
        o_stat.probe_hit   = stop_ok;
        o_stat.probe_miss  = !stop_ok && (stop_empty || (r_count == LAST_IDX));
        o_stat.out_free    = out_free;
    end

    // Channel ports.
    assign i_req.ready      = i_cmd.ready;
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.slot_index = r_out_slot;
    assign o_rsp.entries    = r_out_entries;

endmodule

/* bench/tb_linear_probe_hash_table_core.sv */
// Testbench for linear_probe_hash_table_core: directed and random insert, delete
// and search words, checked against a slot-level table predictor held in the bench.
// Depends on lph_pkg, lph_if and the block's RTL.
`timescale 1ns / 1ps

module tb_linear_probe_hash_table_core;
    import lph_pkg::*;

    localparam int TBL      = DEF_TABLE_SIZE;
    localparam int KEY_POOL = 24;

    // Expected response word.
    typedef struct packed {
        t_status                status;
        logic [SLOT_W-1:0]      slot_index;
        logic [ENTRIES_W-1:0]   entries;
    } t_outcome;

    logic clk;
    logic rst_n;

    lph_req_if req_if ();
    lph_rsp_if rsp_if ();

    linear_probe_hash_table_core #(
        .TABLE_SIZE(TBL)
    ) DUT (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    // Shadow copy of the table, updated in acceptance order.
    t_tag              table_tag [TBL];
    logic [KEY_W-1:0]  table_key [TBL];
    int                live_count;

    t_outcome          pending_outcomes[$];
    logic [KEY_W-1:0]  pool_key  [KEY_POOL];
    logic [HASH_W-1:0] pool_hash [KEY_POOL];

    int mismatches;
    int n_insert, n_delete, n_search, n_full, n_missing;
    int tx_quiet, rx_quiet, rx_stall;

    // Clock.
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial begin
        #10ms;
        $display("Regression FAIL");
        $finish;
    end

    // Gap length: mostly zero or short, a few long, with quiet stretches.
    function automatic int pick_gap(inout int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            quiet = $urandom_range(16, 48);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Random hash whose home slot is the given one.
    function automatic logic [HASH_W-1:0] hash_for_home(int home);
        logic [HASH_W-1:0] h;
        h = HASH_W'($urandom());
        return (h & ~HASH_W'(TBL - 1)) | HASH_W'(home % TBL);
    endfunction

    // Apply one operation to the shadow table and return the response it must give.
    function automatic t_outcome probe_table_op(t_kind op, logic [KEY_W-1:0] key,
                                                logic [HASH_W-1:0] hash);
        t_outcome res;
        int       slot;
        int       n;
        bit       done;
        res.status     = ST_NOT_FOUND;
        res.slot_index = '0;
        done           = 1'b0;
        slot           = int'(hash % TBL);
        if (op == KIND_INSERT) begin
            // First slot that is empty or a tombstone takes the key.
            res.status = ST_FULL;
            for (n = 0; n < TBL && !done; n++) begin
                if (table_tag[slot] != TAG_LIVE) begin
                    table_tag[slot] = TAG_LIVE;
                    table_key[slot] = key;
                    live_count++;
                    res.status     = ST_OK;
                    res.slot_index = SLOT_W'(slot);
                    done           = 1'b1;
                end else begin
                    slot = (slot + 1) % TBL;
                end
            end
        end else if (op == KIND_DELETE || op == KIND_SEARCH) begin
            // Stop at an empty slot, skip tombstones, give up after a full circle.
            for (n = 0; n < TBL && !done; n++) begin
                if (table_tag[slot] == TAG_EMPTY) begin
                    done = 1'b1;
                end else if (table_tag[slot] == TAG_LIVE && table_key[slot] == key) begin
                    if (op == KIND_DELETE) begin
                        table_tag[slot] = TAG_DELETED;
                        if (live_count > 0) live_count--;
                    end
                    res.status     = ST_OK;
                    res.slot_index = SLOT_W'(slot);
                    done           = 1'b1;
                end else begin
                    slot = (slot + 1) % TBL;
                end
            end
        end
        res.entries = ENTRIES_W'(live_count);
        return res;
    endfunction

    // Send one request word and record the response it must produce.
    task automatic send_word(t_kind op, logic [KEY_W-1:0] key, logic [HASH_W-1:0] hash);
        int       gap;
        t_outcome want;
        @(negedge clk);
        gap = pick_gap(tx_quiet);
        if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.kind       = op;
        req_if.key        = key;
        req_if.hash_value = hash;
        req_if.valid      = 1'b1;
        forever begin
            @(posedge clk);
            if (req_if.ready) break;
        end
        want = probe_table_op(op, key, hash);
        pending_outcomes.push_back(want);
        case (op)
            KIND_INSERT: n_insert++;
            KIND_DELETE: n_delete++;
            default:     n_search++;
        endcase
        if (want.status == ST_FULL) n_full++;
        if (want.status == ST_NOT_FOUND) n_missing++;
    endtask

    // Response side: ready drops for random stretches.
    initial begin
        rsp_if.ready = 1'b0;
        rx_stall     = 0;
        forever begin
            @(negedge clk);
            if (rx_stall == 0 && $urandom_range(0, 7) == 0) rx_stall = pick_gap(rx_quiet);
            if (rx_stall > 0) begin
                rsp_if.ready = 1'b0;
                rx_stall--;
            end else begin
                rsp_if.ready = 1'b1;
            end
        end
    end

    // Compare each accepted response word with the oldest expectation.
    always @(posedge clk) begin
        t_outcome want;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected response status=%0d slot=%0d entries=%0d",
                         $realtime, rsp_if.status, rsp_if.slot_index, rsp_if.entries);
                mismatches++;
            end else begin
                want = pending_outcomes.pop_front();
                if (rsp_if.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $realtime, want.status, rsp_if.status);
                    mismatches++;
                end
                if (rsp_if.slot_index !== want.slot_index) begin
                    $display("%0t: slot_index expected %0d actual %0d",
                             $realtime, want.slot_index, rsp_if.slot_index);
                    mismatches++;
                end
                if (rsp_if.entries !== want.entries) begin
                    $display("%0t: entries expected %0d actual %0d",
                             $realtime, want.entries, rsp_if.entries);
                    mismatches++;
                end
            end
        end
    end

    // Lookups on an empty table miss at once.
    task automatic test_empty_table_misses();
        send_word(KIND_SEARCH, 64'h0, 31'h0);
        send_word(KIND_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 31'h7FFF_FFFF);
    endtask

    // Extreme keys and hashes, wraparound, duplicates and tombstones.
    task automatic test_probe_wrap_and_tombstones();
        logic [KEY_W-1:0] key_a;
        logic [KEY_W-1:0] key_b;
        key_a = 64'h5A5A_A5A5_0F0F_F0F0;
        key_b = 64'h0123_4567_89AB_CDEF;
        send_word(KIND_INSERT, 64'h0, 31'h0);
        send_word(KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 31'h7FFF_FFFF);
        // Home is the last slot: probing wraps past slot 0.
        send_word(KIND_INSERT, key_a, 31'd15);
        send_word(KIND_INSERT, key_a, 31'd31);
        send_word(KIND_SEARCH, key_a, 31'd15);
        send_word(KIND_DELETE, key_a, 31'd15);
        // The search skips the new tombstone and finds the duplicate.
        send_word(KIND_SEARCH, key_a, 31'd15);
        send_word(KIND_INSERT, key_b, 31'd1);
        send_word(KIND_DELETE, key_a, 31'd47);
        send_word(KIND_SEARCH, key_a, 31'd15);
    endtask

    // Fill every slot, then insert into the full table and miss a full circle.
    task automatic test_fill_to_full();
        int i;
        for (i = 0; i < TBL; i++) begin
            if (live_count < TBL)
                send_word(KIND_INSERT, {$urandom(), $urandom()},
                          hash_for_home($urandom_range(0, TBL - 1)));
        end
        send_word(KIND_INSERT, 64'hDEAD_0000_BEEF_0001, 31'h4000_0007);
        send_word(KIND_SEARCH, 64'hDEAD_0000_BEEF_0002, 31'h2000_0003);
        send_word(KIND_DELETE, 64'hDEAD_0000_BEEF_0003, 31'h1000_000C);
    endtask

    // Random traffic in alternating fill and drain phases over a small key pool.
    task automatic test_random_traffic(int count);
        int                i, n, p, r, s, phase_left;
        bit                filling;
        t_kind             op;
        logic [KEY_W-1:0]  key;
        logic [HASH_W-1:0] hash;
        for (i = 0; i < KEY_POOL; i++) begin
            pool_key[i]  = {$urandom(), $urandom()};
            pool_hash[i] = (i % 2) ? HASH_W'($urandom())
                                   : hash_for_home(12 + $urandom_range(0, 7));
        end
        filling    = 1'b0;
        phase_left = 0;
        for (i = 0; i < count; i++) begin
            if (phase_left == 0) begin
                filling    = !filling;
                phase_left = $urandom_range(20, 60);
            end
            phase_left--;
            p = $urandom_range(0, KEY_POOL - 1);
            if ($urandom_range(0, 49) == 0) begin
                pool_key[p]  = {$urandom(), $urandom()};
                pool_hash[p] = hash_for_home($urandom_range(0, TBL - 1));
            end
            key  = pool_key[p];
            hash = pool_hash[p];
            r    = $urandom_range(0, 99);
            if (filling) begin
                if (r < 65) begin
                    op = KIND_INSERT;
                    if ($urandom_range(0, 9) < 4) begin
                        key  = {$urandom(), $urandom()};
                        hash = HASH_W'($urandom());
                    end
                end else if (r < 85) begin
                    op = KIND_SEARCH;
                end else begin
                    op = KIND_DELETE;
                end
            end else begin
                op = (r < 65) ? KIND_DELETE : (r < 90) ? KIND_SEARCH : KIND_INSERT;
                // Most drain lookups target a live slot from its own home.
                if (op != KIND_INSERT && live_count > 0 && r % 3 != 0) begin
                    s = $urandom_range(0, TBL - 1);
                    for (n = 0; n < TBL && table_tag[s] != TAG_LIVE; n++) s = (s + 1) % TBL;
                    key  = table_key[s];
                    hash = hash_for_home(s);
                end
            end
            send_word(op, key, hash);
        end
    endtask

    // Main sequence.
    initial begin
        rst_n             = 1'b0;
        req_if.valid      = 1'b0;
        req_if.kind       = KIND_INSERT;
        req_if.key        = '0;
        req_if.hash_value = '0;
        mismatches = 0;
        n_insert   = 0;
        n_delete   = 0;
        n_search   = 0;
        n_full     = 0;
        n_missing  = 0;
        tx_quiet   = 0;
        rx_quiet   = 0;
        live_count = 0;
        for (int i = 0; i < TBL; i++) begin
            table_tag[i] = TAG_EMPTY;
            table_key[i] = '0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table_misses();
        test_probe_wrap_and_tombstones();
        test_fill_to_full();
        test_random_traffic(1820);

        @(negedge clk);
        req_if.valid = 1'b0;
        while (pending_outcomes.size() != 0) @(posedge clk);
        repeat (2 * TBL + 8) @(posedge clk);

        $display("Covered %0d inserts, %0d deletes and %0d searches.",
                 n_insert, n_delete, n_search);
        $display("Outcomes included %0d full-table inserts and %0d failed lookups.",
                 n_full, n_missing);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
src/lph_pkg.sv
src/lph_if.sv
src/lph_ctrl.sv
src/lph_dp.sv
src/linear_probe_hash_table_core.sv
bench/tb_linear_probe_hash_table_core.sv
